>>> rtl/core/wrc_pkg.sv
// shared widths, codes and reset values for the wiegand receiver core
package wrc_pkg;

    localparam int TIMEOUT_W  = 16;
    localparam int COUNT_W    = 8;
    localparam int CODE_W     = 2;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_IDX_W  = 1;

    typedef logic [TIMEOUT_W-1:0] timeout_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [CODE_W-1:0]    line_code_t;

    // result kinds carried on m_tuser
    localparam logic KIND_BIT       = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    // register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BIT_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP_TIMEOUT = 1'b1;

    localparam timeout_t FIRST_BIT_TIMEOUT_RST = 16'd5000;
    localparam timeout_t FRAME_GAP_TIMEOUT_RST = 16'd50;

    // only d1 active decodes as a one
    localparam line_code_t CODE_NONE    = 2'b00;
    localparam line_code_t CODE_D1_ONLY = 2'b10;

    localparam timeout_t ELAPSED_MAX = 16'hFFFF;
    localparam count_t   COUNT_MAX   = 8'hFF;

endpackage

>>> rtl/core/wiegand_receiver_core.sv
// wiegand receiver core: line sampling, bit decode and frame timing
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------------------
//  s_       | in        | s_tvalid / s_tready    | s_tdata: line samples and controls
//  m_       | out       | m_tvalid / m_tready    | m_tuser: result kind, m_tdata: bit/frame
//  cfg_     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data: timeout registers
//
// one item is accepted per clock while the input register is empty or its item steps
// on; each item passes an input register and one step of decode logic into the result
// register, where any result it gives is held until it is taken
// the decode step advances only when the result register is free or being taken
// aresetn clears phase, timer, count and both valid flags, and reloads the timeouts
// cfg_ready is always high
module wiegand_receiver_core #(
    parameter int MAX_FRAME_BITS = 255
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_read, d0_level, d1_level, ms_tick, abort_request, zero pad [7:5]
    input  logic [wrc_pkg::S_TDATA_W-1:0] s_tdata,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // bit_value, line_code [2:1], frame_bits [10:3], zero pad [15:11]
    output logic [wrc_pkg::M_TDATA_W-1:0] m_tdata,
    // result_kind
    output logic                          m_tuser,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wrc_pkg::TIMEOUT_W-1:0] cfg_data
);
    import wrc_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_FIRST,
        PH_GAP,
        PH_RELEASE
    } phase_t;

    localparam count_t MAX_BITS = COUNT_W'(MAX_FRAME_BITS);

    timeout_t   first_timeout_reg;
    timeout_t   gap_timeout_reg;

    logic       in_valid_reg;
    logic [4:0] in_data_reg;

    phase_t     phase_reg, phase_next;
    timeout_t   elapsed_reg, elapsed_next;
    count_t     count_reg, count_next;

    logic       out_valid_reg;
    logic       out_kind_reg;
    logic       out_bit_reg;
    line_code_t out_code_reg;
    count_t     out_bits_reg;

    logic       step_fire;
    logic       start_read, d0_level, d1_level, ms_tick, abort_request;
    line_code_t code;
    timeout_t   elapsed_inc;
    count_t     count_inc;
    logic       res_valid;
    logic       res_kind;
    logic       res_bit;
    line_code_t res_code;
    count_t     res_bits;

    assign step_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step_fire;
    assign cfg_ready = 1'b1;

    assign start_read    = in_data_reg[0];
    assign d0_level      = in_data_reg[1];
    assign d1_level      = in_data_reg[2];
    assign ms_tick       = in_data_reg[3];
    assign abort_request = in_data_reg[4];
    assign code          = {~d1_level, ~d0_level};

    assign elapsed_inc = (ms_tick && elapsed_reg != ELAPSED_MAX) ? elapsed_reg + 1'b1
                                                                 : elapsed_reg;
    assign count_inc   = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;

    always_comb begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        count_next   = count_reg;
        res_valid    = 1'b0;
        res_kind     = KIND_BIT;
        res_bit      = 1'b0;
        res_code     = CODE_NONE;
        res_bits     = '0;

        if (phase_reg == PH_IDLE) begin
            if (start_read) begin
                phase_next   = PH_WAIT_FIRST;
                elapsed_next = '0;
                count_next   = '0;
            end
        end else begin
            elapsed_next = elapsed_inc;
            if (abort_request) begin
                res_valid  = 1'b1;
                res_kind   = KIND_FRAME_END;
                phase_next = PH_IDLE;
            end else begin
                case (phase_reg)
                    PH_WAIT_FIRST: begin
                        if (elapsed_inc > first_timeout_reg) begin
                            res_valid  = 1'b1;
                            res_kind   = KIND_FRAME_END;
                            phase_next = PH_IDLE;
                        end else if (code != CODE_NONE) begin
                            res_valid  = 1'b1;
                            res_bit    = (code == CODE_D1_ONLY);
                            res_code   = code;
                            count_next = count_inc;
                            phase_next = PH_RELEASE;
                        end
                    end
                    PH_GAP: begin
                        if (code != CODE_NONE) begin
                            res_valid  = 1'b1;
                            res_bit    = (code == CODE_D1_ONLY);
                            res_code   = code;
                            count_next = count_inc;
                            phase_next = PH_RELEASE;
                        end else if (elapsed_inc > gap_timeout_reg) begin
                            res_valid  = 1'b1;
                            res_kind   = KIND_FRAME_END;
                            res_bits   = count_reg;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_RELEASE: begin
                        if (code == CODE_NONE) begin
                            elapsed_next = '0;
                            if (count_reg >= MAX_BITS) begin
                                res_valid  = 1'b1;
                                res_kind   = KIND_FRAME_END;
                                phase_next = PH_IDLE;
                            end else begin
                                phase_next = PH_GAP;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_timeout_reg <= FIRST_BIT_TIMEOUT_RST;
            gap_timeout_reg   <= FRAME_GAP_TIMEOUT_RST;
            in_valid_reg      <= 1'b0;
            phase_reg         <= PH_IDLE;
            elapsed_reg       <= '0;
            count_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FIRST_BIT_TIMEOUT: first_timeout_reg <= cfg_data;
                    CFG_FRAME_GAP_TIMEOUT: gap_timeout_reg   <= cfg_data;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (step_fire) begin
                in_valid_reg <= 1'b0;
            end

            if (step_fire) begin
                phase_reg     <= phase_next;
                elapsed_reg   <= elapsed_next;
                count_reg     <= count_next;
                out_valid_reg <= res_valid;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[4:0];
        end
        if (step_fire) begin
            out_kind_reg <= res_kind;
            out_bit_reg  <= res_bit;
            out_code_reg <= res_code;
            out_bits_reg <= res_bits;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {5'b0, out_bits_reg, out_code_reg, out_bit_reg};

endmodule

>>> rtl/core/wrc_checker.sv
// port-level checks for the wiegand receiver core, bound to wiegand_receiver_core
module wrc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wrc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import wrc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no result straight after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // frame end carries only a count
    a_end_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_FRAME_END |-> m_tdata[2:0] == 3'b000)
        else $error("frame end with bit fields set");

    // bit item has an active line, no count, and decodes d1-only as one
    a_bit_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_BIT |->
            m_tdata[2:1] != CODE_NONE && m_tdata[10:3] == 8'd0 &&
            m_tdata[0] == (m_tdata[2:1] == CODE_D1_ONLY))
        else $error("bit item fields inconsistent");

endmodule

bind wiegand_receiver_core wrc_checker u_wrc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
